[rtl/blw_pkg.sv]
// ----------------------------------------------------------------------------
// blw_pkg
// Shared types and constants of the Bresenham line walker.
// ----------------------------------------------------------------------------
package blw_pkg;

  // Item command
  typedef enum logic [0:0] {
    FUNC_START   = 1'b0,
    FUNC_ADVANCE = 1'b1
  } func_e;

  // Configuration register index (byte address bit 2)
  typedef enum logic [0:0] {
    REG_SURF_WIDTH  = 1'b0,
    REG_SURF_HEIGHT = 1'b1
  } reg_idx_e;

  localparam int unsigned SURF_BITS    = 12;
  localparam int unsigned PADDR_BITS   = 3;
  localparam int unsigned PDATA_BITS   = 32;
  localparam int unsigned COLOR_BITS   = 32;
  localparam int unsigned QUEUE_DEPTH  = 4;

  localparam logic [SURF_BITS-1:0] SURF_WIDTH_RST  = 12'd640;
  localparam logic [SURF_BITS-1:0] SURF_HEIGHT_RST = 12'd480;

endpackage

[rtl/blw_front.sv]
// ----------------------------------------------------------------------------
// blw_front
// Input stage: accepts items, takes endpoint deltas, and classifies each
// start into major axis, walk direction and start point.
// ----------------------------------------------------------------------------
module blw_front #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  blw_pkg::func_e                func_i,
  input  logic [COORD_BITS-1:0]         start_x_i,
  input  logic [COORD_BITS-1:0]         start_y_i,
  input  logic [COORD_BITS-1:0]         end_x_i,
  input  logic [COORD_BITS-1:0]         end_y_i,
  input  logic [blw_pkg::COLOR_BITS-1:0] color_i,
  // toward the queue
  output logic                          push_o,
  input  logic                          queue_full_i,
  output blw_pkg::func_e                func_o,
  output logic                          steep_o,
  output logic                          minor_neg_o,
  output logic [COORD_BITS-1:0]         sx_o,
  output logic [COORD_BITS-1:0]         sy_o,
  output logic [COORD_BITS-1:0]         major_end_o,
  output logic [COORD_BITS-1:0]         dmaj_o,
  output logic [COORD_BITS-1:0]         dmin_o,
  output logic [blw_pkg::COLOR_BITS-1:0] color_o
);
  import blw_pkg::*;

  localparam int unsigned DW = COORD_BITS + 1;

  logic                    valid_q, valid_d;
  func_e                   func_q;
  logic [COORD_BITS-1:0]   ax_q, ay_q, bx_q, by_q;
  logic [COLOR_BITS-1:0]   color_q;
  logic signed [DW-1:0]    dx_q, dy_q;
  logic                    accept;

  logic [DW-1:0]           adx_w, ady_w;
  logic [COORD_BITS-1:0]   adx, ady;
  logic                    steep, swap;

  assign in_stall_o = valid_q && queue_full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = valid_q && !queue_full_i;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload: load on transfer, take the deltas here
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q  <= func_i;
      ax_q    <= start_x_i;
      ay_q    <= start_y_i;
      bx_q    <= end_x_i;
      by_q    <= end_y_i;
      color_q <= color_i;
      dx_q    <= $signed({end_x_i[COORD_BITS-1], end_x_i})
               - $signed({start_x_i[COORD_BITS-1], start_x_i});
      dy_q    <= $signed({end_y_i[COORD_BITS-1], end_y_i})
               - $signed({start_y_i[COORD_BITS-1], start_y_i});
    end
  end

  // Classify: major axis, swap to walk toward increasing major coordinate
  always_comb begin
    adx_w = dx_q[DW-1] ? DW'(-dx_q) : DW'(dx_q);
    ady_w = dy_q[DW-1] ? DW'(-dy_q) : DW'(dy_q);
    adx   = adx_w[COORD_BITS-1:0];
    ady   = ady_w[COORD_BITS-1:0];
    steep = adx < ady;
    swap  = steep ? dy_q[DW-1] : dx_q[DW-1];
    if (steep) begin
      minor_neg_o = swap ? !dx_q[DW-1] : (dx_q <= 0);
      dmaj_o      = ady;
      dmin_o      = adx;
      major_end_o = swap ? ay_q : by_q;
    end else begin
      minor_neg_o = swap ? !dy_q[DW-1] : (dy_q <= 0);
      dmaj_o      = adx;
      dmin_o      = ady;
      major_end_o = swap ? ax_q : bx_q;
    end
    sx_o    = swap ? bx_q : ax_q;
    sy_o    = swap ? by_q : ay_q;
    steep_o = steep;
    func_o  = func_q;
    color_o = color_q;
  end

endmodule

[rtl/blw_queue.sv]
// ----------------------------------------------------------------------------
// blw_queue
// Small register FIFO between the classifier and the walker.
// ----------------------------------------------------------------------------
module blw_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o,
  output logic             full_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CW'(DEPTH));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

[rtl/blw_walker.sv]
// ----------------------------------------------------------------------------
// blw_walker
// Walk state and output register: sets up the error term on start and
// steps one major-axis unit per advance.
// ----------------------------------------------------------------------------
module blw_walker #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // from the queue
  input  logic                          q_valid_i,
  output logic                          q_pop_o,
  input  blw_pkg::func_e                func_i,
  input  logic                          steep_i,
  input  logic                          minor_neg_i,
  input  logic [COORD_BITS-1:0]         sx_i,
  input  logic [COORD_BITS-1:0]         sy_i,
  input  logic [COORD_BITS-1:0]         major_end_i,
  input  logic [COORD_BITS-1:0]         dmaj_i,
  input  logic [COORD_BITS-1:0]         dmin_i,
  input  logic [blw_pkg::COLOR_BITS-1:0] color_i,
  // surface size
  input  logic [blw_pkg::SURF_BITS-1:0] surf_width_i,
  input  logic [blw_pkg::SURF_BITS-1:0] surf_height_i,
  // output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [COORD_BITS-1:0]         pix_x_o,
  output logic [COORD_BITS-1:0]         pix_y_o,
  output logic [blw_pkg::COLOR_BITS-1:0] pix_color_o,
  output logic                          on_surface_o,
  output logic                          last_pixel_o
);
  import blw_pkg::*;

  localparam int unsigned EW   = COORD_BITS + 4;
  localparam int unsigned CMPW = (COORD_BITS > SURF_BITS) ? COORD_BITS : SURF_BITS;

  // walk state
  logic                   busy_q, busy_d;
  logic [COORD_BITS-1:0]  cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [COORD_BITS-1:0]  major_end_q, major_end_d;
  logic signed [EW-1:0]   err_q, err_d, diag_incr_q, diag_incr_d;
  logic signed [EW-1:0]   straight_incr_q, straight_incr_d;
  logic                   minor_neg_q, minor_neg_d, steep_q, steep_d;
  logic [COLOR_BITS-1:0]  color_q, color_d;

  // output register
  logic                   out_valid_q;
  logic [COORD_BITS-1:0]  pix_x_q, pix_y_q;
  logic [COLOR_BITS-1:0]  pix_color_q;
  logic                   last_q;

  logic                   fire, emit, last;
  logic [COORD_BITS-1:0]  maj_next, min_next, min_cur, min_step;
  logic signed [EW-1:0]   dmin2, dmaj1, dmaj2;
  logic                   take_diag;

  assign fire    = q_valid_i && (!out_valid_q || !out_stall_i);
  assign q_pop_o = fire;

  always_comb begin
    busy_d          = busy_q;
    cur_x_d         = cur_x_q;
    cur_y_d         = cur_y_q;
    major_end_d     = major_end_q;
    err_d           = err_q;
    diag_incr_d     = diag_incr_q;
    straight_incr_d = straight_incr_q;
    minor_neg_d     = minor_neg_q;
    steep_d         = steep_q;
    color_d         = color_q;
    emit            = 1'b0;
    last            = 1'b0;

    dmin2     = $signed(EW'({dmin_i, 1'b0}));
    dmaj1     = $signed(EW'(dmaj_i));
    dmaj2     = $signed(EW'({dmaj_i, 1'b0}));
    take_diag = !err_q[EW-1];
    maj_next  = (steep_q ? cur_y_q : cur_x_q) + 1'b1;
    min_cur   = steep_q ? cur_x_q : cur_y_q;
    min_step  = minor_neg_q ? '1 : COORD_BITS'(1);
    min_next  = take_diag ? min_cur + min_step : min_cur;

    if (fire) begin
      case (func_i)
        FUNC_START: begin
          // set up the line and emit its first pixel
          cur_x_d         = sx_i;
          cur_y_d         = sy_i;
          major_end_d     = major_end_i;
          steep_d         = steep_i;
          minor_neg_d     = minor_neg_i;
          color_d         = color_i;
          err_d           = dmin2 - dmaj1;
          diag_incr_d     = dmin2 - dmaj2;
          straight_incr_d = dmin2;
          last            = (steep_i ? sy_i : sx_i) == major_end_i;
          busy_d          = !last;
          emit            = 1'b1;
        end
        FUNC_ADVANCE: begin
          // idle walker drops the advance
          if (busy_q) begin
            if (steep_q) begin
              cur_y_d = maj_next;
              cur_x_d = min_next;
            end else begin
              cur_x_d = maj_next;
              cur_y_d = min_next;
            end
            err_d  = err_q + (take_diag ? diag_incr_q : straight_incr_q);
            last   = $signed(maj_next) >= $signed(major_end_q);
            busy_d = !last;
            emit   = 1'b1;
          end
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      if (fire && emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_x_q         <= cur_x_d;
    cur_y_q         <= cur_y_d;
    major_end_q     <= major_end_d;
    err_q           <= err_d;
    diag_incr_q     <= diag_incr_d;
    straight_incr_q <= straight_incr_d;
    minor_neg_q     <= minor_neg_d;
    steep_q         <= steep_d;
    color_q         <= color_d;
    if (fire && emit) begin
      pix_x_q     <= cur_x_d;
      pix_y_q     <= cur_y_d;
      pix_color_q <= color_d;
      last_q      <= last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pix_x_o      = pix_x_q;
  assign pix_y_o      = pix_y_q;
  assign pix_color_o  = pix_color_q;
  assign last_pixel_o = last_q;
  // user changes surface size only while idle (not enforced), so compare at output
  assign on_surface_o = !pix_x_q[COORD_BITS-1] && !pix_y_q[COORD_BITS-1]
                     && (CMPW'(pix_x_q) < CMPW'(surf_width_i))
                     && (CMPW'(pix_y_q) < CMPW'(surf_height_i));

endmodule

[rtl/bresenham_line_walker_core.sv]
// ----------------------------------------------------------------------------
// bresenham_line_walker_core
// Bresenham line rasterizer with surface visibility flag per pixel.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o): each transfer carries one item.
//   func_i = start loads two signed endpoints and a color and yields the
//   first pixel; func_i = advance yields the next pixel of the running line.
//   An advance while no line is running yields nothing.
//   Output channel (out_valid_o / out_stall_i): one pixel per transfer, with
//   on_surface_o and last_pixel_o; after the last pixel the walker is idle.
//   Path: an accepted item is held in the classifier register, written
//   into the queue from there, and the walker output register is loaded
//   straight from the queue head.
//   Throughput: one item per cycle while nothing stalls; the walker does one
//   add-and-compare step per cycle, and the classifier one subtract per cycle.
//   Stall: the output register holds its pixel, the four-entry queue fills,
//   then the classifier holds and in_stall_o rises.
//   Reset: walker idle, queue empty, surface 640 x 480. Config: APB writes to
//   0x0 (width) and 0x4 (height), by the user only while idle (not enforced).
// ----------------------------------------------------------------------------
module bresenham_line_walker_core #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // input channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               func_i,
  input  logic [COORD_BITS-1:0]              start_x_i,
  input  logic [COORD_BITS-1:0]              start_y_i,
  input  logic [COORD_BITS-1:0]              end_x_i,
  input  logic [COORD_BITS-1:0]              end_y_i,
  input  logic [blw_pkg::COLOR_BITS-1:0]     color_i,
  // output channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [COORD_BITS-1:0]              pix_x_o,
  output logic [COORD_BITS-1:0]              pix_y_o,
  output logic [blw_pkg::COLOR_BITS-1:0]     pix_color_o,
  output logic                               on_surface_o,
  output logic                               last_pixel_o,
  // configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [blw_pkg::PADDR_BITS-1:0]     paddr,
  input  logic [blw_pkg::PDATA_BITS-1:0]     pwdata,
  output logic [blw_pkg::PDATA_BITS-1:0]     prdata,
  output logic                               pready
);
  import blw_pkg::*;

  // queue entry: func, steep, minor_neg, sx, sy, major_end, dmaj, dmin, color
  localparam int unsigned QW = 3 + 5 * COORD_BITS + COLOR_BITS;

  logic [SURF_BITS-1:0]  surf_width_q, surf_height_q;
  logic                  cfg_wr;
  reg_idx_e              reg_idx;

  func_e                 f_func;
  logic                  f_push, f_steep, f_minor_neg;
  logic [COORD_BITS-1:0] f_sx, f_sy, f_major_end, f_dmaj, f_dmin;
  logic [COLOR_BITS-1:0] f_color;

  logic [QW-1:0]         q_wdata, q_rdata;
  logic                  q_empty, q_full, q_pop;

  logic                  w_func_bit, w_steep, w_minor_neg;
  logic [COORD_BITS-1:0] w_sx, w_sy, w_major_end, w_dmaj, w_dmin;
  logic [COLOR_BITS-1:0] w_color;

  // Configuration registers: write on the access phase, read any time
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      surf_width_q  <= SURF_WIDTH_RST;
      surf_height_q <= SURF_HEIGHT_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_SURF_WIDTH:  surf_width_q  <= pwdata[SURF_BITS-1:0];
        REG_SURF_HEIGHT: surf_height_q <= pwdata[SURF_BITS-1:0];
        default: begin
          surf_width_q <= surf_width_q;
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SURF_WIDTH:  prdata = PDATA_BITS'(surf_width_q);
      REG_SURF_HEIGHT: prdata = PDATA_BITS'(surf_height_q);
      default:         prdata = '0;
    endcase
  end

  // Front: accept and classify
  blw_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .func_i       (func_e'(func_i)),
    .start_x_i    (start_x_i),
    .start_y_i    (start_y_i),
    .end_x_i      (end_x_i),
    .end_y_i      (end_y_i),
    .color_i      (color_i),
    .push_o       (f_push),
    .queue_full_i (q_full),
    .func_o       (f_func),
    .steep_o      (f_steep),
    .minor_neg_o  (f_minor_neg),
    .sx_o         (f_sx),
    .sy_o         (f_sy),
    .major_end_o  (f_major_end),
    .dmaj_o       (f_dmaj),
    .dmin_o       (f_dmin),
    .color_o      (f_color)
  );

  // Queue: decouple classifier from walker
  assign q_wdata = {f_func, f_steep, f_minor_neg, f_sx, f_sy, f_major_end,
                    f_dmaj, f_dmin, f_color};

  blw_queue #(
    .WIDTH(QW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .wdata_i (q_wdata),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  assign {w_func_bit, w_steep, w_minor_neg, w_sx, w_sy, w_major_end,
          w_dmaj, w_dmin, w_color} = q_rdata;

  // Back: walk and present pixels
  blw_walker #(
    .COORD_BITS(COORD_BITS)
  ) u_walker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (!q_empty),
    .q_pop_o       (q_pop),
    .func_i        (func_e'(w_func_bit)),
    .steep_i       (w_steep),
    .minor_neg_i   (w_minor_neg),
    .sx_i          (w_sx),
    .sy_i          (w_sy),
    .major_end_i   (w_major_end),
    .dmaj_i        (w_dmaj),
    .dmin_i        (w_dmin),
    .color_i       (w_color),
    .surf_width_i  (surf_width_q),
    .surf_height_i (surf_height_q),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pix_x_o       (pix_x_o),
    .pix_y_o       (pix_y_o),
    .pix_color_o   (pix_color_o),
    .on_surface_o  (on_surface_o),
    .last_pixel_o  (last_pixel_o)
  );

endmodule
